>>> rtl/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/dhcp_lr_pkg.sv
`timescale 1ns / 1ps
package dhcp_lr_pkg;

   localparam int REQ_DATA_W = 264;
   localparam int RSP_DATA_W = 136;
   localparam int REQ_USER_W = 8;
   localparam int RSP_USER_W = 4;
   localparam int TIMEOUT_W  = 16;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;

   localparam logic [7:0] MT_OFFER = 8'd2;
   localparam logic [7:0] MT_ACK   = 8'd5;
   localparam logic [7:0] MT_NAK   = 8'd6;

   localparam logic [1:0] SEND_RENEW    = 2'd0;
   localparam logic [1:0] SEND_REBIND   = 2'd1;
   localparam logic [1:0] SEND_DISCOVER = 2'd2;
   localparam logic [1:0] SEND_REQUEST  = 2'd3;

   localparam logic [1:0] PATH_RENEW     = 2'd0;
   localparam logic [1:0] PATH_REBIND    = 2'd1;
   localparam logic [1:0] PATH_REACQUIRE = 2'd2;

   typedef struct packed {
      logic        query_ok;
      logic [31:0] lease_seconds;
      logic [31:0] elapsed_ticks;
      logic [31:0] renew_at_ticks;
      logic [31:0] rebind_at_ticks;
      logic [31:0] now_tick;
      logic        reply_valid;
      logic [7:0]  reply_type;
      logic [31:0] reply_address;
      logic [31:0] reply_renew_time;
      logic [31:0] reply_lease_time;
   } req_item_type;

   typedef struct packed {
      logic        send_valid;
      logic [1:0]  send_kind;
      logic [31:0] send_address;
      logic        apply_valid;
      logic [31:0] apply_address;
      logic [31:0] apply_renew_time;
      logic [31:0] apply_lease_time;
      logic [1:0]  apply_path;
      logic        fallback_static;
   } rsp_item_type;

endpackage

>>> rtl/dhcp_lr_engine.sv
`timescale 1ns / 1ps
module dhcp_lr_engine
   import dhcp_lr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [TIMEOUT_W-1:0] timeout,
   input  req_item_type         item,
   output rsp_item_type         result
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_RENEW  = 3'd1,
      PH_REBIND = 3'd2,
      PH_OFFER  = 3'd3,
      PH_ACK    = 3'd4
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [31:0]  start_ff, start_in;
   rsp_item_type result_ff, result_in;

   logic [31:0] since;
   logic [31:0] rebind_window;
   logic        is_ack, is_nak, is_offer, wait_over, rebind_over;
   logic        past_t1, past_t2;

   assign since         = item.now_tick - start_ff;
   assign rebind_window = item.rebind_at_ticks - item.renew_at_ticks;
   assign wait_over     = since > {{(32-TIMEOUT_W){1'b0}}, timeout};
   assign rebind_over   = since > rebind_window;
   assign past_t1       = item.elapsed_ticks >= item.renew_at_ticks;
   assign past_t2       = item.elapsed_ticks >= item.rebind_at_ticks;
   assign is_ack        = item.reply_valid && (item.reply_type == MT_ACK);
   assign is_nak        = item.reply_valid && (item.reply_type == MT_NAK);
   assign is_offer      = item.reply_valid && (item.reply_type == MT_OFFER);

   always_comb begin
      result_in = '0;
      phase_in  = phase_ff;
      start_in  = start_ff;
      if (!item.query_ok) begin
         phase_in = phase_ff;
      end else if (item.lease_seconds == 32'd0) begin
         phase_in = PH_IDLE;
      end else begin
         unique case (phase_ff)
            PH_RENEW, PH_REBIND: begin
               if (item.reply_valid) begin
                  if (is_ack) begin
                     result_in.apply_valid      = 1'b1;
                     result_in.apply_address    = item.reply_address;
                     result_in.apply_renew_time = item.reply_renew_time;
                     result_in.apply_lease_time = item.reply_lease_time;
                     result_in.apply_path = (phase_ff == PH_RENEW) ? PATH_RENEW
                                                                  : PATH_REBIND;
                     phase_in = PH_IDLE;
                  end else if (is_nak) begin
                     result_in.send_valid = 1'b1;
                     result_in.send_kind  = SEND_DISCOVER;
                     phase_in = PH_OFFER;
                     start_in = item.now_tick;
                  end
               end else if (phase_ff == PH_RENEW) begin
                  if (past_t2) begin
                     result_in.send_valid = 1'b1;
                     result_in.send_kind  = SEND_REBIND;
                     phase_in = PH_REBIND;
                     start_in = item.now_tick;
                  end
               end else if (rebind_over) begin
                  result_in.send_valid = 1'b1;
                  result_in.send_kind  = SEND_DISCOVER;
                  phase_in = PH_OFFER;
                  start_in = item.now_tick;
               end
            end
            PH_OFFER: begin
               if (is_offer) begin
                  result_in.send_valid   = 1'b1;
                  result_in.send_kind    = SEND_REQUEST;
                  result_in.send_address = item.reply_address;
                  phase_in = PH_ACK;
                  start_in = item.now_tick;
               end else if (wait_over) begin
                  result_in.fallback_static = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            PH_ACK: begin
               if (item.reply_valid) begin
                  if (is_ack) begin
                     result_in.apply_valid      = 1'b1;
                     result_in.apply_address    = item.reply_address;
                     result_in.apply_renew_time = item.reply_renew_time;
                     result_in.apply_lease_time = item.reply_lease_time;
                     result_in.apply_path       = PATH_REACQUIRE;
                     phase_in = PH_IDLE;
                  end else if (is_nak) begin
                     result_in.send_valid = 1'b1;
                     result_in.send_kind  = SEND_DISCOVER;
                     phase_in = PH_OFFER;
                     start_in = item.now_tick;
                  end
               end else if (wait_over) begin
                  result_in.fallback_static = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               if (past_t2) begin
                  result_in.send_valid = 1'b1;
                  result_in.send_kind  = SEND_REBIND;
                  phase_in = PH_REBIND;
                  start_in = item.now_tick;
               end else if (past_t1) begin
                  result_in.send_valid = 1'b1;
                  result_in.send_kind  = SEND_RENEW;
                  phase_in = PH_RENEW;
                  start_in = item.now_tick;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         start_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/dhcp_lease_renewal_fsm.sv
`timescale 1ns / 1ps
// DHCP lease renewal controller.
// req channel: one word per heartbeat tick (lease query, T1/T2 thresholds,
// current tick and an optional received reply; reply type on req_tuser).
// rsp channel: exactly one word per tick: a send request (renew, rebind,
// discover, request), an acked lease to apply tagged with its path, or a
// static fallback flag; the word is all zero when nothing happens.
// csr port: write the reacquire timeout at any idle time; no read-back.
// Datapath: a word accepted on req goes into the input register, then through
// one pass of decision logic into the result register that drives rsp.
// Throughput: one word per cycle while rsp_tready is high.
// Reset: phase goes idle, the wait start tick clears and the timeout
// returns to 200; both registers empty.
// Stall: while rsp_tready is low the result word holds; one more word can
// sit in the input register, after which req_tready drops.
`include "assert_macros.svh"
module dhcp_lease_renewal_fsm
   import dhcp_lr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // query_ok, lease_seconds, elapsed_ticks, renew_at_ticks, rebind_at_ticks,
   // now_tick, reply_valid, reply_address, reply_renew_time, reply_lease_time
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // reply_type
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // send_valid, send_address, apply_valid, apply_address, apply_renew_time,
   // apply_lease_time, fallback_static
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // send_kind, apply_path
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [TIMEOUT_W-1:0]  csr_wr_data
);

   logic [TIMEOUT_W-1:0] timeout_ff;
   logic                 req_valid_ff;
   logic                 rsp_valid_ff;
   req_item_type         req_ff, req_in;
   rsp_item_type         result;
   logic                 advance;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_comb begin
      req_in.query_ok         = req_tdata[0];
      req_in.lease_seconds    = req_tdata[32:1];
      req_in.elapsed_ticks    = req_tdata[64:33];
      req_in.renew_at_ticks   = req_tdata[96:65];
      req_in.rebind_at_ticks  = req_tdata[128:97];
      req_in.now_tick         = req_tdata[160:129];
      req_in.reply_valid      = req_tdata[161];
      req_in.reply_type       = req_tuser;
      req_in.reply_address    = req_tdata[193:162];
      req_in.reply_renew_time = req_tdata[225:194];
      req_in.reply_lease_time = req_tdata[257:226];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_tvalid && req_tready) begin
         req_ff <= req_in;
      end
   end

   dhcp_lr_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .timeout (timeout_ff),
      .item    (req_ff),
      .result  (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0,
                        result.fallback_static,
                        result.apply_lease_time,
                        result.apply_renew_time,
                        result.apply_address,
                        result.apply_valid,
                        result.send_address,
                        result.send_valid};
   assign rsp_tuser  = {result.apply_path, result.send_kind};

   `ASSERT_SAME(a_one_action, clock, reset, rsp_valid_ff,
      !(result.send_valid && result.apply_valid) &&
      !(result.fallback_static && (result.send_valid || result.apply_valid)))
   `ASSERT_SAME(a_idle_fields_zero, clock, reset, rsp_valid_ff && !result.apply_valid,
      (result.apply_path == PATH_RENEW) && (result.apply_address == 32'd0))
   `ASSERT_SAME(a_path_legal, clock, reset, rsp_valid_ff && result.apply_valid,
      result.apply_path != 2'd3)
   `ASSERT_NEXT(a_full_blocks, clock, reset,
      req_valid_ff && rsp_valid_ff && !rsp_tready, req_valid_ff && rsp_valid_ff)

endmodule

>>> bench/dhcp_lease_checker.sv
`timescale 1ns / 1ps
module dhcp_lease_checker
   import dhcp_lr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [TIMEOUT_W-1:0]  csr_wr_data,
   output int                    fail_count,
   output int                    words_owed
);

   typedef enum logic [2:0] {
      LS_IDLE   = 3'd0,
      LS_RENEW  = 3'd1,
      LS_REBIND = 3'd2,
      LS_OFFER  = 3'd3,
      LS_ACK    = 3'd4
   } lease_phase_type;

   lease_phase_type      lease_phase;
   logic [31:0]          wait_start;
   logic [TIMEOUT_W-1:0] reacquire_limit;
   rsp_item_type         owed_actions[$];
   req_item_type         tick;
   rsp_item_type         got, want;
   int                   errs = 0;

   function automatic rsp_item_type next_lease_action(input req_item_type t);
      rsp_item_type r;
      logic [31:0]  since;
      r = '0;
      since = t.now_tick - wait_start;
      if (!t.query_ok)
         return r;
      if (t.lease_seconds == 32'd0) begin
         lease_phase = LS_IDLE;
         return r;
      end
      case (lease_phase)
         LS_RENEW, LS_REBIND: begin
            if (t.reply_valid) begin
               if (t.reply_type == MT_ACK) begin
                  r.apply_valid      = 1'b1;
                  r.apply_address    = t.reply_address;
                  r.apply_renew_time = t.reply_renew_time;
                  r.apply_lease_time = t.reply_lease_time;
                  r.apply_path       = (lease_phase == LS_RENEW) ? PATH_RENEW : PATH_REBIND;
                  lease_phase        = LS_IDLE;
               end else if (t.reply_type == MT_NAK) begin
                  r.send_valid = 1'b1;
                  r.send_kind  = SEND_DISCOVER;
                  lease_phase  = LS_OFFER;
                  wait_start   = t.now_tick;
               end
            end else if (lease_phase == LS_RENEW) begin
               if (t.elapsed_ticks >= t.rebind_at_ticks) begin
                  r.send_valid = 1'b1;
                  r.send_kind  = SEND_REBIND;
                  lease_phase  = LS_REBIND;
                  wait_start   = t.now_tick;
               end
            end else if (since > t.rebind_at_ticks - t.renew_at_ticks) begin
               r.send_valid = 1'b1;
               r.send_kind  = SEND_DISCOVER;
               lease_phase  = LS_OFFER;
               wait_start   = t.now_tick;
            end
         end
         LS_OFFER: begin
            if (t.reply_valid && t.reply_type == MT_OFFER) begin
               r.send_valid   = 1'b1;
               r.send_kind    = SEND_REQUEST;
               r.send_address = t.reply_address;
               lease_phase    = LS_ACK;
               wait_start     = t.now_tick;
            end else if (since > {16'd0, reacquire_limit}) begin
               r.fallback_static = 1'b1;
               lease_phase       = LS_IDLE;
            end
         end
         LS_ACK: begin
            if (t.reply_valid) begin
               if (t.reply_type == MT_ACK) begin
                  r.apply_valid      = 1'b1;
                  r.apply_address    = t.reply_address;
                  r.apply_renew_time = t.reply_renew_time;
                  r.apply_lease_time = t.reply_lease_time;
                  r.apply_path       = PATH_REACQUIRE;
                  lease_phase        = LS_IDLE;
               end else if (t.reply_type == MT_NAK) begin
                  r.send_valid = 1'b1;
                  r.send_kind  = SEND_DISCOVER;
                  lease_phase  = LS_OFFER;
                  wait_start   = t.now_tick;
               end
            end else if (since > {16'd0, reacquire_limit}) begin
               r.fallback_static = 1'b1;
               lease_phase       = LS_IDLE;
            end
         end
         default: begin
            if (t.elapsed_ticks >= t.rebind_at_ticks) begin
               r.send_valid = 1'b1;
               r.send_kind  = SEND_REBIND;
               lease_phase  = LS_REBIND;
               wait_start   = t.now_tick;
            end else if (t.elapsed_ticks >= t.renew_at_ticks) begin
               r.send_valid = 1'b1;
               r.send_kind  = SEND_RENEW;
               lease_phase  = LS_RENEW;
               wait_start   = t.now_tick;
            end else begin
               lease_phase = LS_IDLE;
            end
         end
      endcase
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_val,
                                       input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %h, got %h", name, exp_val, act_val);
         errs++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         lease_phase     = LS_IDLE;
         wait_start      = '0;
         reacquire_limit = TIMEOUT_RESET;
         owed_actions.delete();
      end else begin
         if (csr_wr_en)
            reacquire_limit = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.send_valid       = rsp_tdata[0];
            got.send_address     = rsp_tdata[32:1];
            got.apply_valid      = rsp_tdata[33];
            got.apply_address    = rsp_tdata[65:34];
            got.apply_renew_time = rsp_tdata[97:66];
            got.apply_lease_time = rsp_tdata[129:98];
            got.fallback_static  = rsp_tdata[130];
            got.send_kind        = rsp_tuser[1:0];
            got.apply_path       = rsp_tuser[3:2];
            if (owed_actions.size() == 0) begin
               $error("unexpected rsp word %h / %h", rsp_tdata, rsp_tuser);
               errs++;
            end else begin
               want = owed_actions.pop_front();
               check_field("send_valid", want.send_valid, got.send_valid);
               check_field("send_kind", want.send_kind, got.send_kind);
               check_field("send_address", want.send_address, got.send_address);
               check_field("apply_valid", want.apply_valid, got.apply_valid);
               check_field("apply_address", want.apply_address, got.apply_address);
               check_field("apply_renew_time", want.apply_renew_time, got.apply_renew_time);
               check_field("apply_lease_time", want.apply_lease_time, got.apply_lease_time);
               check_field("apply_path", want.apply_path, got.apply_path);
               check_field("fallback_static", want.fallback_static, got.fallback_static);
            end
         end
         if (req_tvalid && req_tready) begin
            tick.query_ok         = req_tdata[0];
            tick.lease_seconds    = req_tdata[32:1];
            tick.elapsed_ticks    = req_tdata[64:33];
            tick.renew_at_ticks   = req_tdata[96:65];
            tick.rebind_at_ticks  = req_tdata[128:97];
            tick.now_tick         = req_tdata[160:129];
            tick.reply_valid      = req_tdata[161];
            tick.reply_address    = req_tdata[193:162];
            tick.reply_renew_time = req_tdata[225:194];
            tick.reply_lease_time = req_tdata[257:226];
            tick.reply_type       = req_tuser[7:0];
            owed_actions.push_back(next_lease_action(tick));
         end
      end
      words_owed <= owed_actions.size();
      fail_count <= errs;
   end

endmodule

>>> bench/tb_dhcp_lease_renewal_fsm.sv
`timescale 1ns / 1ps
module tb_dhcp_lease_renewal_fsm;
   import dhcp_lr_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_WORDS   = 190;
   localparam int PHASES        = 6;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_wr_en;
   logic [TIMEOUT_W-1:0]  csr_wr_data;

   int          fail_count;
   int          words_owed;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_token     = 0;
   int          quiet_cycles   = 0;
   logic [31:0] now_tick;
   logic [31:0] lease_origin;
   logic [31:0] renew_thresh;
   logic [31:0] rebind_thresh;

   dhcp_lease_renewal_fsm DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dhcp_lease_checker lease_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .words_owed  (words_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_dhcp_lease_renewal_fsm: done, errors");
            $finish;
         end
      end
   end

   task automatic push_tick(input req_item_type t);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, t.reply_lease_time, t.reply_renew_time, t.reply_address,
                     t.reply_valid, t.now_tick, t.rebind_at_ticks, t.renew_at_ticks,
                     t.elapsed_ticks, t.lease_seconds, t.query_ok};
      req_tuser  <= t.reply_type;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic step_tick(input logic ok, input logic [31:0] lease, input logic [31:0] el,
                            input logic [31:0] t1, input logic [31:0] t2,
                            input logic [31:0] adv, input logic rv, input logic [7:0] mt);
      req_item_type t;
      now_tick          = now_tick + adv;
      t.query_ok         = ok;
      t.lease_seconds    = lease;
      t.elapsed_ticks    = el;
      t.renew_at_ticks   = t1;
      t.rebind_at_ticks  = t2;
      t.now_tick         = now_tick;
      t.reply_valid      = rv;
      t.reply_type       = mt;
      t.reply_address    = $urandom;
      t.reply_renew_time = $urandom;
      t.reply_lease_time = $urandom;
      push_tick(t);
   endtask

   function automatic req_item_type random_tick();
      req_item_type t;
      logic [287:0] noise;
      int           roll;
      roll = $urandom_range(99);
      if (roll < 85)
         now_tick = now_tick + $urandom_range(3);
      else if (roll < 95)
         now_tick = now_tick + $urandom_range(300, 4);
      else
         now_tick = now_tick + $urandom_range(140000, 301);
      if ($urandom_range(99) < 3 || now_tick - lease_origin > rebind_thresh + 32'd200) begin
         lease_origin  = now_tick;
         renew_thresh  = $urandom_range(40, 1);
         rebind_thresh = renew_thresh + $urandom_range(40);
         roll          = $urandom_range(19);
         if (roll == 0) begin
            renew_thresh  = $urandom;
            rebind_thresh = $urandom;
         end else if (roll == 1) begin
            rebind_thresh = renew_thresh - 32'd1;
         end
      end
      t.query_ok         = $urandom_range(99) >= 4;
      t.lease_seconds    = ($urandom_range(99) < 3) ? 32'd0 : 32'($urandom);
      t.elapsed_ticks    = now_tick - lease_origin;
      t.renew_at_ticks   = renew_thresh;
      t.rebind_at_ticks  = rebind_thresh;
      t.now_tick         = now_tick;
      t.reply_valid      = $urandom_range(99) < 30;
      roll               = $urandom_range(99);
      t.reply_type       = (roll < 30) ? MT_OFFER : (roll < 60) ? MT_ACK :
                           (roll < 85) ? MT_NAK : 8'($urandom);
      t.reply_address    = $urandom;
      t.reply_renew_time = $urandom;
      t.reply_lease_time = $urandom;
      if ($urandom_range(99) < 8) begin
         for (int i = 0; i < 9; i++)
            noise[i*32 +: 32] = $urandom;
         t = noise[257:0];
      end
      return t;
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      now_tick = 32'hFFFF_FFF0;
      step_tick(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1, 1'b1, MT_ACK);
      step_tick(1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1, 1'b0, MT_OFFER);
      step_tick(1'b1, 32'hFFFF_FFFF, 32'd10, 32'd10, 32'd20, 32'd1, 1'b0, MT_OFFER);
      step_tick(1'b1, 32'd7, 32'd30, 32'd10, 32'd20, 32'd1, 1'b1, 8'hFF);
      step_tick(1'b1, 32'd7, 32'd11, 32'd10, 32'd20, 32'd1, 1'b1, MT_ACK);
      step_tick(1'b1, 32'd7, 32'd25, 32'd10, 32'd20, 32'd1, 1'b0, MT_ACK);
      step_tick(1'b1, 32'd7, 32'd26, 32'd10, 32'd20, 32'd1, 1'b1, 8'h00);
      step_tick(1'b1, 32'd7, 32'd27, 32'd10, 32'd20, 32'd1, 1'b1, MT_ACK);
      step_tick(1'b1, 32'd7, 32'd12, 32'd10, 32'd20, 32'd1, 1'b0, MT_ACK);
      step_tick(1'b1, 32'd7, 32'd21, 32'd10, 32'd20, 32'd1, 1'b0, MT_ACK);
      step_tick(1'b1, 32'd7, 32'd22, 32'd10, 32'd20, 32'd10, 1'b0, MT_ACK);
      step_tick(1'b1, 32'd7, 32'd23, 32'd10, 32'd20, 32'd1, 1'b0, MT_ACK);
      step_tick(1'b1, 32'd7, 32'd0, 32'd10, 32'd20, 32'd1, 1'b1, MT_ACK);
      step_tick(1'b1, 32'd7, 32'd0, 32'd10, 32'd20, 32'd1, 1'b1, MT_OFFER);
      step_tick(1'b1, 32'd7, 32'd0, 32'd10, 32'd20, 32'd1, 1'b1, MT_OFFER);
      step_tick(1'b1, 32'd7, 32'd0, 32'd10, 32'd20, 32'd1, 1'b1, MT_NAK);
      step_tick(1'b1, 32'd7, 32'd0, 32'd10, 32'd20, 32'd201, 1'b0, MT_OFFER);
      step_tick(1'b1, 32'd7, 32'd10, 32'd10, 32'd20, 32'd1, 1'b0, MT_OFFER);
      step_tick(1'b1, 32'd7, 32'd10, 32'd10, 32'd20, 32'd1, 1'b1, MT_NAK);
      step_tick(1'b1, 32'd7, 32'd0, 32'd10, 32'd20, 32'd1, 1'b1, MT_OFFER);
      step_tick(1'b1, 32'd7, 32'd0, 32'd10, 32'd20, 32'd1, 1'b1, MT_ACK);
      step_tick(1'b1, 32'd7, 32'd10, 32'd10, 32'd20, 32'd1, 1'b0, MT_OFFER);
      step_tick(1'b1, 32'd0, 32'd10, 32'd10, 32'd20, 32'd1, 1'b0, MT_OFFER);
      step_tick(1'b1, 32'd7, 32'd10, 32'd10, 32'd20, 32'd1, 1'b0, MT_OFFER);
      step_tick(1'b1, 32'd7, 32'd10, 32'd10, 32'd20, 32'd1, 1'b1, MT_NAK);
      step_tick(1'b1, 32'd7, 32'd0, 32'd10, 32'd20, 32'd1, 1'b1, MT_OFFER);
      step_tick(1'b1, 32'd7, 32'd0, 32'd10, 32'd20, 32'd200, 1'b0, MT_OFFER);
      step_tick(1'b1, 32'd7, 32'd0, 32'd10, 32'd20, 32'd1, 1'b0, MT_OFFER);

      lease_origin  = now_tick;
      renew_thresh  = 32'd10;
      rebind_thresh = 32'd30;
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0:       write_timeout(16'd0);
            1:       write_timeout(16'hFFFF);
            2:       write_timeout(16'd1);
            4:       write_timeout(TIMEOUT_RESET);
            default: write_timeout(TIMEOUT_W'($urandom_range(40, 2)));
         endcase
         case (ph % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         if (ph == 4)
            hold_token++;
         repeat (PHASE_WORDS) push_tick(random_tick());
      end
      drain();

      if (fail_count == 0)
         $display("tb_dhcp_lease_renewal_fsm: done, clean");
      else
         $display("tb_dhcp_lease_renewal_fsm: done, errors");
      $finish;
   end

endmodule
